// File: rtl/tst_pkg.sv
// ----------------------------------------------------------------------------
// tst_pkg
// Shared types and constants of the thick stroke to triangles block.
// ----------------------------------------------------------------------------
`default_nettype none

package tst_pkg;

    localparam logic [15:0] BOARD_WIDTH_RST  = 16'd5120;
    localparam logic [15:0] BOARD_HEIGHT_RST = 16'd3840;
    localparam logic [11:0] HALF_THICK_RST   = 12'd32;

    localparam logic [1:0] REG_BOARD_WIDTH  = 2'd0;
    localparam logic [1:0] REG_BOARD_HEIGHT = 2'd1;
    localparam logic [1:0] REG_HALF_THICK   = 2'd2;

    localparam logic OP_ADD_POINT = 1'b0;
    localparam logic OP_END_LINE  = 1'b1;

    localparam logic [1:0] KIND_VERTEX    = 2'd0;
    localparam logic [1:0] KIND_COMMITTED = 2'd1;
    localparam logic [1:0] KIND_DISCARDED = 2'd2;

    localparam logic [2:0] VTX_LAST = 3'd5;

    // commands from controller to datapath
    typedef struct packed {
        logic       take_in;
        logic       store_pt;
        logic       end_line;
        logic       prep_mul;
        logic       prep_sq;
        logic       trial_sq;
        logic       trial_lo;
        logic       trial_hi;
        logic       trial_cmp;
        logic       set_offs;
        logic       emit_vtx;
        logic [2:0] vtx_idx;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic is_end;
        logic reject;
        logic prev_set;
        logic dx_zero;
        logic bit_last;
    } t_sts;

endpackage

`default_nettype wire

// File: rtl/tst_dp.sv
// ----------------------------------------------------------------------------
// tst_dp
// Datapath: registers, point state, offset search and vertex output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tst_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [1:0]     i_cfg_addr,
    input  wire logic [15:0]    i_cfg_wdata,
    input  wire logic           i_op,
    input  wire logic [15:0]    i_x,
    input  wire logic [15:0]    i_y,
    input  wire tst_pkg::t_cmd  i_cmd,
    output tst_pkg::t_sts       o_sts,
    output logic [1:0]          o_kind,
    output logic [17:0]         o_vx,
    output logic [17:0]         o_vy,
    output logic                o_last
);
    import tst_pkg::*;

    logic [15:0] r_bw, r_bh;
    logic [11:0] r_t;
    logic        r_op;
    logic [15:0] r_x, r_y, r_px, r_py;
    logic        r_has_seg;
    logic [27:0] r_tax, r_tay;
    logic [31:0] r_sqx, r_sqy;
    logic [55:0] r_rhsx, r_rhsy;
    logic [32:0] r_s;
    logic [11:0] r_bit, r_qx, r_qy;
    logic [25:0] r_dsqx, r_dsqy;
    logic [42:0] r_plox, r_ploy;
    logic [41:0] r_phix, r_phiy;
    logic signed [12:0] r_xoff;
    logic [11:0] r_yoff;
    logic [1:0]  r_kind;
    logic [17:0] r_vx, r_vy;
    logic        r_last;

    logic        dx_neg, dy_neg, dy_zero;
    logic [15:0] adx, ady;
    logic [11:0] cx, cy;
    logic [12:0] dvx, dvy;
    logic [58:0] sumx, sumy;
    logic        okx, oky;
    logic        use_cur, plus;
    logic signed [17:0] bx, by, ox, oy;

    always_comb begin
        dx_neg  = r_x < r_px;
        dy_neg  = r_y < r_py;
        dy_zero = r_y == r_py;
        adx     = dx_neg ? r_px - r_x : r_x - r_px;
        ady     = dy_neg ? r_py - r_y : r_y - r_py;
        cx      = r_qx | r_bit;
        cy      = r_qy | r_bit;
        dvx     = {cx, 1'b0} - 13'd1;
        dvy     = {cy, 1'b0} - 13'd1;
        sumx    = 59'(r_plox) + (59'(r_phix) << 17);
        sumy    = 59'(r_ploy) + (59'(r_phiy) << 17);
        okx     = sumx <= {1'b0, r_rhsx, 2'b00};
        oky     = sumy <= {1'b0, r_rhsy, 2'b00};
    end

    assign o_sts.is_end   = r_op == OP_END_LINE;
    assign o_sts.reject   = (r_x > r_bw) || (r_y > r_bh) || (r_x == r_px && r_y == r_py);
    assign o_sts.prev_set = (r_px != 16'd0) || (r_py != 16'd0);
    assign o_sts.dx_zero  = r_x == r_px;
    assign o_sts.bit_last = r_bit[0];

    // vertex order: v1, v2, v3, v3, v4, v2
    always_comb begin
        use_cur = (i_cmd.vtx_idx == 3'd0) || (i_cmd.vtx_idx == 3'd1)
               || (i_cmd.vtx_idx == VTX_LAST);
        plus    = (i_cmd.vtx_idx == 3'd0) || (i_cmd.vtx_idx == 3'd2)
               || (i_cmd.vtx_idx == 3'd3);
        bx      = use_cur ? $signed({2'b00, r_x}) : $signed({2'b00, r_px});
        by      = use_cur ? $signed({2'b00, r_y}) : $signed({2'b00, r_py});
        ox      = 18'(r_xoff);
        oy      = $signed({6'd0, r_yoff});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bw      <= BOARD_WIDTH_RST;
            r_bh      <= BOARD_HEIGHT_RST;
            r_t       <= HALF_THICK_RST;
            r_px      <= '0;
            r_py      <= '0;
            r_has_seg <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_BOARD_WIDTH:  r_bw <= i_cfg_wdata;
                    REG_BOARD_HEIGHT: r_bh <= i_cfg_wdata;
                    REG_HALF_THICK:   r_t  <= i_cfg_wdata[11:0];
                    default: ;
                endcase
            end
            if (i_cmd.store_pt) begin
                r_px <= r_x;
                r_py <= r_y;
            end
            if (i_cmd.emit_vtx && i_cmd.vtx_idx == VTX_LAST) begin
                r_px      <= r_x;
                r_py      <= r_y;
                r_has_seg <= 1'b1;
            end
            if (i_cmd.end_line) begin
                r_px      <= '0;
                r_py      <= '0;
                r_has_seg <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_op <= i_op;
            r_x  <= i_x;
            r_y  <= i_y;
        end
        if (i_cmd.prep_mul) begin
            r_tax <= 28'(r_t) * 28'(ady);
            r_tay <= 28'(r_t) * 28'(adx);
            r_sqx <= 32'(adx) * 32'(adx);
            r_sqy <= 32'(ady) * 32'(ady);
            r_bit <= 12'h800;
            r_qx  <= '0;
            r_qy  <= '0;
        end
        if (i_cmd.prep_sq) begin
            r_rhsx <= 56'(r_tax) * 56'(r_tax);
            r_rhsy <= 56'(r_tay) * 56'(r_tay);
            r_s    <= 33'(r_sqx) + 33'(r_sqy);
        end
        if (i_cmd.trial_sq) begin
            r_dsqx <= 26'(dvx) * 26'(dvx);
            r_dsqy <= 26'(dvy) * 26'(dvy);
        end
        if (i_cmd.trial_lo) begin
            r_plox <= 43'(r_dsqx) * 43'(r_s[16:0]);
            r_ploy <= 43'(r_dsqy) * 43'(r_s[16:0]);
        end
        if (i_cmd.trial_hi) begin
            r_phix <= 42'(r_dsqx) * 42'(r_s[32:17]);
            r_phiy <= 42'(r_dsqy) * 42'(r_s[32:17]);
        end
        if (i_cmd.trial_cmp) begin
            if (okx) r_qx <= cx;
            if (oky) r_qy <= cy;
            r_bit <= r_bit >> 1;
        end
        if (i_cmd.set_offs) begin
            if (o_sts.dx_zero) begin
                r_xoff <= $signed({1'b0, r_t});
                r_yoff <= '0;
            end else begin
                r_xoff <= ((dx_neg != dy_neg) && !dy_zero) ? -$signed({1'b0, r_qx})
                                                           : $signed({1'b0, r_qx});
                r_yoff <= r_qy;
            end
        end
        if (i_cmd.emit_vtx) begin
            r_kind <= KIND_VERTEX;
            r_vx   <= plus ? bx + ox : bx - ox;
            r_vy   <= plus ? by - oy : by + oy;
            r_last <= i_cmd.vtx_idx == VTX_LAST;
        end
        if (i_cmd.end_line) begin
            r_kind <= r_has_seg ? KIND_COMMITTED : KIND_DISCARDED;
            r_vx   <= '0;
            r_vy   <= '0;
            r_last <= 1'b1;
        end
    end

    assign o_kind = r_kind;
    assign o_vx   = r_vx;
    assign o_vy   = r_vy;
    assign o_last = r_last;

endmodule

`default_nettype wire

// File: rtl/tst_ctrl.sv
// ----------------------------------------------------------------------------
// tst_ctrl
// Controller: sequences decode, offset search and the six vertex emits.
// ----------------------------------------------------------------------------
`default_nettype none

module tst_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire tst_pkg::t_sts i_sts,
    output tst_pkg::t_cmd      o_cmd
);
    import tst_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_CHECK = 10'b00_0000_0010,
        S_PMUL  = 10'b00_0000_0100,
        S_PSQ   = 10'b00_0000_1000,
        S_TSQ   = 10'b00_0001_0000,
        S_TLO   = 10'b00_0010_0000,
        S_THI   = 10'b00_0100_0000,
        S_TCMP  = 10'b00_1000_0000,
        S_OFFS  = 10'b01_0000_0000,
        S_EMIT  = 10'b10_0000_0000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_idx, n_idx;
    logic       r_ovld, n_ovld;
    logic       out_free;

    assign out_free    = !r_ovld || i_out_ready;
    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_ovld;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_ovld  = r_ovld && !i_out_ready;
        o_cmd   = '0;
        o_cmd.vtx_idx = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take_in = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (i_sts.is_end) begin
                    // hold until the output register is free
                    if (out_free) begin
                        o_cmd.end_line = 1'b1;
                        n_ovld  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (i_sts.reject) begin
                    n_state = S_IDLE;
                end else if (!i_sts.prev_set) begin
                    o_cmd.store_pt = 1'b1;
                    n_state = S_IDLE;
                end else if (i_sts.dx_zero) begin
                    n_state = S_OFFS;
                end else begin
                    n_state = S_PMUL;
                end
            end
            S_PMUL: begin
                o_cmd.prep_mul = 1'b1;
                n_state = S_PSQ;
            end
            S_PSQ: begin
                o_cmd.prep_sq = 1'b1;
                n_state = S_TSQ;
            end
            S_TSQ: begin
                o_cmd.trial_sq = 1'b1;
                n_state = S_TLO;
            end
            S_TLO: begin
                o_cmd.trial_lo = 1'b1;
                n_state = S_THI;
            end
            S_THI: begin
                o_cmd.trial_hi = 1'b1;
                n_state = S_TCMP;
            end
            S_TCMP: begin
                o_cmd.trial_cmp = 1'b1;
                n_state = i_sts.bit_last ? S_OFFS : S_TSQ;
            end
            S_OFFS: begin
                o_cmd.set_offs = 1'b1;
                n_idx   = '0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    o_cmd.emit_vtx = 1'b1;
                    n_ovld = 1'b1;
                    n_idx  = r_idx + 3'd1;
                    if (r_idx == VTX_LAST) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_ovld  <= n_ovld;
        end
    end

endmodule

`default_nettype wire

// File: rtl/thick_stroke_to_triangles.sv
// ----------------------------------------------------------------------------
// thick_stroke_to_triangles
// Expands stroke points into the two triangles of a thick segment quad.
// ----------------------------------------------------------------------------
// The block takes one request at a time. An end-line request puts its single
// result in the output register from the check state, once that register is
// free. A dropped or first point gives no result; in both cases the block goes
// back to idle from the check state. A point that closes a segment has its
// perpendicular offsets searched one bit at a time over 12 bits, and each
// trial runs through the square of the candidate, the two partial products
// against the squared length, then the compare. A vertical segment skips the
// search and goes straight to the offset setting. The six vertices then leave
// at one per cycle while the receiver keeps up; a stall of the receiver holds
// them back. After the sixth vertex the block goes back to idle and can take
// the next request. The last result may still wait in the output register
// while the next request is taken.
`default_nettype none

module thick_stroke_to_triangles (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // x_coord[15:0], y_coord[31:16]
    input  wire logic        s_axis_tuser,   // operation
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // vertex_x[17:0], vertex_y[35:18], zeros
    output logic [1:0]       m_axis_tuser,   // kind
    output logic             m_axis_tlast    // last_of_run
);
    import tst_pkg::*;

    t_cmd        cmd;
    t_sts        sts;
    logic [17:0] vx, vy;

    tst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    tst_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op        (s_axis_tuser),
        .i_x         (s_axis_tdata[15:0]),
        .i_y         (s_axis_tdata[31:16]),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_kind      (m_axis_tuser),
        .o_vx        (vx),
        .o_vy        (vy),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, vy, vx};

endmodule

`default_nettype wire
